@@ src/vertex_triple_dedup_indexer_core_macros.svh @@
// Assertion macros shared by the vertex deduplication indexer RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef VERTEX_TRIPLE_DEDUP_INDEXER_CORE_MACROS_SVH
`define VERTEX_TRIPLE_DEDUP_INDEXER_CORE_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define VTDI_ASSERT_ALWAYS(name, expr) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("vtdi: invariant violated");

// When the trigger holds, the condition must hold in the next cycle.
`define VTDI_ASSERT_NEXT(name, trig, expr) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (expr)) \
    else $error("vtdi: sequence violated");

`endif

@@ src/vtdi_pkg.sv @@
// Shared constants, types and the bucket hash of the vertex deduplication indexer.
// No dependencies; used by the controller, the datapath and the top level.
package vtdi_pkg;

  localparam int MAX_VERTS = 4096;
  localparam int BUCKETS   = 1024;
  localparam int ATTR_BITS = 16;

  localparam int IN_W      = 16;
  localparam int OUT_IDX_W = 12;
  localparam int ADDR_W    = $clog2(MAX_VERTS);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int BKT_W     = $clog2(BUCKETS);
  localparam int KEY_W     = 3 * ATTR_BITS;
  localparam int EPOCH_W   = 8;
  localparam int HEAD_W    = EPOCH_W + CNT_W;
  localparam int HASH_MUL  = 31;

  typedef struct packed {
    logic capture;
    logic clr_step;
    logic walk_start;
    logic walk_next;
    logic res_hit;
    logic res_miss;
  } vtdi_cmd_t;

  typedef struct packed {
    logic new_mesh;
    logic epoch_max;
    logic clr_last;
    logic cur_ok;
    logic key_match;
    logic slot_free;
  } vtdi_stat_t;

  // Wrapping 31x hash, kept only in the bucket bits since the bucket count
  // is a power of two.
  function automatic logic [BKT_W-1:0] bucket_of(input logic [ATTR_BITS-1:0] p,
                                                 input logic [ATTR_BITS-1:0] t,
                                                 input logic [ATTR_BITS-1:0] n);
    logic [BKT_W-1:0] h;
    h = BKT_W'(1);
    h = BKT_W'(h * BKT_W'(HASH_MUL)) + BKT_W'(p);
    h = BKT_W'(h * BKT_W'(HASH_MUL)) + BKT_W'(t);
    h = BKT_W'(h * BKT_W'(HASH_MUL)) + BKT_W'(n);
    return h;
  endfunction

endpackage

@@ src/vtdi_ctrl.sv @@
// Controller of the vertex deduplication indexer: sequences clear, lookup and insert.
// Depends on vtdi_pkg for the command and status structs.
module vtdi_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  vtdi_pkg::vtdi_stat_t stat_i,
  output vtdi_pkg::vtdi_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HWAIT,
    S_HCHK,
    S_CMP
  } state_e;

  state_e state_q, state_d;
  logic   pending_q, pending_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d   = state_q;
    pending_d = pending_q;
    cmd_o     = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          state_d   = pending_q ? S_HWAIT : S_IDLE;
          pending_d = 1'b0;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (stat_i.new_mesh && stat_i.epoch_max) begin
            state_d   = S_CLEAR;
            pending_d = 1'b1;
          end else begin
            state_d = S_HWAIT;
          end
        end
      end
      S_HWAIT: begin
        state_d = S_HCHK;
      end
      S_HCHK: begin
        cmd_o.walk_start = 1'b1;
        state_d          = S_CMP;
      end
      S_CMP: begin
        if (!stat_i.cur_ok) begin
          if (stat_i.slot_free) begin
            cmd_o.res_miss = 1'b1;
            state_d        = S_IDLE;
          end
        end else if (stat_i.key_match) begin
          if (stat_i.slot_free) begin
            cmd_o.res_hit = 1'b1;
            state_d       = S_IDLE;
          end
        end else begin
          cmd_o.walk_next = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      pending_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pending_q <= pending_d;
    end
  end

endmodule

@@ src/vtdi_dpath.sv @@
// Datapath of the vertex deduplication indexer: key, link and bucket head memories,
// vertex count, mesh epoch, walk pointer and the output register. Uses vtdi_pkg.
`include "vertex_triple_dedup_indexer_core_macros.svh"

module vtdi_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  vtdi_pkg::vtdi_cmd_t           cmd_i,
  output vtdi_pkg::vtdi_stat_t          stat_o,
  input  logic [vtdi_pkg::IN_W-1:0]     position_index_i,
  input  logic [vtdi_pkg::IN_W-1:0]     texcoord_index_i,
  input  logic [vtdi_pkg::IN_W-1:0]     normal_index_i,
  input  logic                          new_mesh_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [vtdi_pkg::OUT_IDX_W-1:0] vertex_index_o,
  output logic                          is_new_o,
  output logic                          table_full_o
);

  logic [vtdi_pkg::KEY_W-1:0]   key_mem  [vtdi_pkg::MAX_VERTS];
  logic [vtdi_pkg::CNT_W-1:0]   link_mem [vtdi_pkg::MAX_VERTS];
  logic [vtdi_pkg::HEAD_W-1:0]  head_mem [vtdi_pkg::BUCKETS];

  logic [vtdi_pkg::KEY_W-1:0]   key_q, key_rd_q;
  logic [vtdi_pkg::CNT_W-1:0]   link_rd_q;
  logic [vtdi_pkg::HEAD_W-1:0]  head_rd_q;
  logic [vtdi_pkg::BKT_W-1:0]   bucket_q, clr_q;
  logic [vtdi_pkg::CNT_W-1:0]   count_q, cur_q, head_ptr_q;
  logic [vtdi_pkg::EPOCH_W-1:0] epoch_q;
  logic                         out_valid_q, is_new_q, full_q;
  logic [vtdi_pkg::OUT_IDX_W-1:0] idx_q;

  logic [vtdi_pkg::KEY_W-1:0]   key_in;
  logic [vtdi_pkg::CNT_W-1:0]   head_eff, rd_ptr;
  logic [vtdi_pkg::ADDR_W-1:0]  rd_addr, wr_addr;
  logic                         is_full, ins_we, head_we;
  logic [vtdi_pkg::BKT_W-1:0]   head_waddr;
  logic [vtdi_pkg::HEAD_W-1:0]  head_wdata;

  assign key_in = {position_index_i[vtdi_pkg::ATTR_BITS-1:0],
                   texcoord_index_i[vtdi_pkg::ATTR_BITS-1:0],
                   normal_index_i[vtdi_pkg::ATTR_BITS-1:0]};

  // A head written in an earlier mesh reads as an empty bucket.
  assign head_eff = (head_rd_q[vtdi_pkg::HEAD_W-1 -: vtdi_pkg::EPOCH_W] == epoch_q)
                    ? head_rd_q[vtdi_pkg::CNT_W-1:0]
                    : vtdi_pkg::CNT_W'(vtdi_pkg::MAX_VERTS);

  assign rd_ptr  = cmd_i.walk_start ? head_eff : (cmd_i.walk_next ? link_rd_q : cur_q);
  assign rd_addr = rd_ptr[vtdi_pkg::ADDR_W-1:0];
  assign wr_addr = count_q[vtdi_pkg::ADDR_W-1:0];

  assign is_full    = (count_q >= vtdi_pkg::CNT_W'(vtdi_pkg::MAX_VERTS));
  assign ins_we     = cmd_i.res_miss && !is_full;
  assign head_we    = cmd_i.clr_step || ins_we;
  assign head_waddr = cmd_i.clr_step ? clr_q : bucket_q;
  assign head_wdata = cmd_i.clr_step
                      ? {epoch_q, vtdi_pkg::CNT_W'(vtdi_pkg::MAX_VERTS)}
                      : {epoch_q, count_q};

  always_ff @(posedge clk_i) begin
    if (ins_we) begin
      key_mem[wr_addr]  <= key_q;
      link_mem[wr_addr] <= head_ptr_q;
    end
    key_rd_q  <= key_mem[rd_addr];
    link_rd_q <= link_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    head_rd_q <= head_mem[bucket_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      key_q    <= key_in;
      bucket_q <= vtdi_pkg::bucket_of(key_in[vtdi_pkg::KEY_W-1 -: vtdi_pkg::ATTR_BITS],
                                      key_in[2*vtdi_pkg::ATTR_BITS-1 -: vtdi_pkg::ATTR_BITS],
                                      key_in[vtdi_pkg::ATTR_BITS-1:0]);
    end
    if (cmd_i.walk_start) begin
      head_ptr_q <= head_eff;
    end
    if (cmd_i.walk_start || cmd_i.walk_next) begin
      cur_q <= rd_ptr;
    end
    if (cmd_i.res_hit) begin
      idx_q    <= cur_q[vtdi_pkg::OUT_IDX_W-1:0];
      is_new_q <= 1'b0;
      full_q   <= 1'b0;
    end else if (cmd_i.res_miss) begin
      idx_q    <= is_full ? '0 : count_q[vtdi_pkg::OUT_IDX_W-1:0];
      is_new_q <= !is_full;
      full_q   <= is_full;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      epoch_q     <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.capture && new_mesh_i) begin
        count_q <= '0;
        epoch_q <= epoch_q + 1'b1;
      end else if (ins_we) begin
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.res_hit || cmd_i.res_miss) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.new_mesh  = new_mesh_i;
  assign stat_o.epoch_max = &epoch_q;
  assign stat_o.clr_last  = (clr_q == vtdi_pkg::BKT_W'(vtdi_pkg::BUCKETS - 1));
  assign stat_o.cur_ok    = (cur_q < count_q);
  assign stat_o.key_match = (key_rd_q == key_q);
  assign stat_o.slot_free = !out_valid_q || !out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign vertex_index_o = idx_q;
  assign is_new_o       = is_new_q;
  assign table_full_o   = full_q;

  `VTDI_ASSERT_ALWAYS(a_count_bound, count_q <= vtdi_pkg::CNT_W'(vtdi_pkg::MAX_VERTS))
  `VTDI_ASSERT_ALWAYS(a_new_xor_full, !(out_valid_q && is_new_q && full_q))
  `VTDI_ASSERT_NEXT(a_insert_counts, ins_we, count_q == $past(count_q) + 1'b1)
  `VTDI_ASSERT_ALWAYS(a_hit_in_range, !(cmd_i.res_hit && !(cur_q < count_q)))

endmodule

@@ src/vertex_triple_dedup_indexer_core.sv @@
// Top level of the vertex deduplication indexer: controller plus datapath.
// Depends on vtdi_pkg, vtdi_ctrl and vtdi_dpath.
//
//   channel | valid        | stall        | payload
//   input   | in_valid_i   | in_stall_o   | position/texcoord/normal_index_i, new_mesh_i
//   output  | out_valid_o  | out_stall_i  | vertex_index_o, is_new_o, table_full_o
//
// An item passes through capture and hash, the bucket head read and the walk start,
// then one key and link memory read per chain entry compared, and one more compare
// when the walk runs off the end of the chain. An empty bucket or a hit on the first
// entry therefore ends at its first compare. The single read port of the key and link
// memories limits the walk to one chain entry per read.
// After reset a clearing pass writes every bucket head empty; no item is accepted
// meanwhile. Every 256th mesh start runs the same pass first.
// A result waits in an output register while out_stall_i is high; the next item
// is accepted meanwhile and its lookup stops before its result if the slot is full.
module vertex_triple_dedup_indexer_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [vtdi_pkg::IN_W-1:0]      position_index_i,
  input  logic [vtdi_pkg::IN_W-1:0]      texcoord_index_i,
  input  logic [vtdi_pkg::IN_W-1:0]      normal_index_i,
  input  logic                           new_mesh_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [vtdi_pkg::OUT_IDX_W-1:0] vertex_index_o,
  output logic                           is_new_o,
  output logic                           table_full_o
);

  // Commands go from the controller to the datapath; status comes back.
  vtdi_pkg::vtdi_cmd_t  cmd;
  vtdi_pkg::vtdi_stat_t stat;

  vtdi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  vtdi_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .position_index_i (position_index_i),
    .texcoord_index_i (texcoord_index_i),
    .normal_index_i   (normal_index_i),
    .new_mesh_i       (new_mesh_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .vertex_index_o   (vertex_index_o),
    .is_new_o         (is_new_o),
    .table_full_o     (table_full_o)
  );

endmodule
